### design/steer_pkg.sv
// Package for the steering agent: payload types, codes, datapath commands, saturation helpers
`timescale 1ns / 1ps
`default_nettype none

package steer_pkg;

    localparam int DataW = 32;
    localparam int CfgIdxW = 3;

    // command codes
    localparam logic [2:0] CMD_SEEK   = 3'd0;
    localparam logic [2:0] CMD_ARRIVE = 3'd1;
    localparam logic [2:0] CMD_REPEL  = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_STEP   = 3'd4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_FORCE    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SLOW_RADIUS  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_REPEL_RADIUS = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REPEL_SPAN   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_REPEL_GAIN   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_START_X      = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_START_Y      = 3'd7;

    // configuration reset values
    localparam logic [30:0] RST_MAX_SPEED    = 31'd262144;
    localparam logic [30:0] RST_MAX_FORCE    = 31'd6554;
    localparam logic [30:0] RST_SLOW_RADIUS  = 31'd6553600;
    localparam logic [30:0] RST_REPEL_RADIUS = 31'd3276800;
    localparam logic [30:0] RST_REPEL_SPAN   = 31'd6553600;
    localparam logic [16:0] RST_REPEL_GAIN   = 17'd1311;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF_TP,
        OP_DIFF_PT,
        OP_VEL_ACC,
        OP_SQ_X,
        OP_SQ_Y,
        OP_LIMSQ,
        OP_SQRT_GO,
        OP_SET_SEEK,
        OP_SET_LIMIT,
        OP_SET_WEIGH,
        OP_DIV_X,
        OP_DIV_Y,
        OP_WB_X,
        OP_WB_Y,
        OP_ZERO_V,
        OP_STEER,
        OP_ACC_ADD,
        OP_GAIN_X,
        OP_GAIN_Y,
        OP_ACC_REP,
        OP_CLEAR_REP,
        OP_STEP_END,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic len_zero;
        logic len_ge_radius;
        logic span_zero;
        logic within_limit;
        logic sqrt_done;
        logic div_done;
    } dp_status_t;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    function automatic logic signed [65:0] sx66(input logic signed [31:0] a);
        return {{34{a[31]}}, a};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

endpackage

`default_nettype wire

### design/steer_sqrt.sv
// Iterative 64-bit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module steer_sqrt
    import steer_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] s_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;
    logic        fits;

    assign trial = res_reg + bit_reg;
    assign fits  = (s_reg >= trial);
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg)
        begin
            if (fits)
            begin
                s_reg   <= s_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

`default_nettype wire

### design/steer_div.sv
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module steer_div
    import steer_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        fits;

    assign shifted  = {rem_reg, dvd_reg[63]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign fits     = (shifted >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg)
        begin
            rem_reg <= fits ? diff[31:0] : shifted[31:0];
            dvd_reg <= {dvd_reg[62:0], fits};
        end
    end

endmodule

`default_nettype wire

### design/steer_dp.sv
// Steering datapath: agent state, configuration, multiplier, root and divide units
`timescale 1ns / 1ps
`default_nettype none

module steer_dp
    import steer_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_op_t             op,
    input  wire in_t                in_data,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [DataW-1:0]   cfg_data,
    output dp_status_t              status,
    output out_t                    out_data
);

    // configuration
    logic [30:0]        max_speed_reg;
    logic [30:0]        max_force_reg;
    logic [30:0]        slow_radius_reg;
    logic [30:0]        repel_radius_reg;
    logic [30:0]        repel_span_reg;
    logic [16:0]        repel_gain_reg;
    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;

    // agent state
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic signed [31:0] rep_x_reg, rep_y_reg;

    // working registers
    logic [2:0]         cmd_reg;
    logic signed [31:0] tgt_x_reg, tgt_y_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        limsq_reg;
    logic [31:0]        len_reg;
    logic [31:0]        num_reg;
    logic [31:0]        den_reg;
    logic               wneg_reg;
    out_t               out_reg;

    logic [31:0]        mag_x, mag_y;
    logic [31:0]        lim;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    logic               sqrt_done, div_done;
    logic [31:0]        root;
    logic [63:0]        div_q;
    logic signed [65:0] q66;
    logic signed [31:0] wb_x, wb_y;
    logic signed [65:0] gain66;
    logic signed [65:0] gain_s;
    logic signed [32:0] weight;
    logic [32:0]        weight_mag;
    logic               slow_now;

    assign mag_x = mag32(vx_reg);
    assign mag_y = mag32(vy_reg);
    assign lim   = (cmd_reg == CMD_STEP) ? {1'b0, max_speed_reg} : {1'b0, max_force_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            OP_SQ_X:   begin mul_a = mag_x; mul_b = mag_x; end
            OP_SQ_Y:   begin mul_a = mag_y; mul_b = mag_y; end
            OP_LIMSQ:  begin mul_a = lim;   mul_b = lim;   end
            OP_DIV_X:  begin mul_a = mag_x; mul_b = num_reg; end
            OP_DIV_Y:  begin mul_a = mag_y; mul_b = num_reg; end
            OP_GAIN_X: begin mul_a = mag_x; mul_b = {15'd0, repel_gain_reg}; end
            OP_GAIN_Y: begin mul_a = mag_y; mul_b = {15'd0, repel_gain_reg}; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    steer_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == OP_SQRT_GO),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    steer_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((op == OP_DIV_X) || (op == OP_DIV_Y)),
        .dividend (prod),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // apply sign to the quotient and clamp
    assign q66  = $signed({2'b00, div_q});
    assign wb_x = sat32((vx_reg[31] ^ wneg_reg) ? -q66 : q66);
    assign wb_y = sat32((vy_reg[31] ^ wneg_reg) ? -q66 : q66);

    // gain product, truncated toward zero
    assign gain66 = $signed({18'd0, prod[63:16]});
    assign gain_s = ((op == OP_GAIN_Y) ? vy_reg[31] : vx_reg[31]) ? -gain66 : gain66;

    assign weight     = $signed({2'b00, repel_span_reg}) - $signed({1'b0, len_reg});
    assign weight_mag = weight[32] ? (~weight + 33'd1) : weight;
    assign slow_now   = (cmd_reg == CMD_ARRIVE) && (len_reg < {1'b0, slow_radius_reg});

    assign status.len_zero      = (len_reg == '0);
    assign status.len_ge_radius = (len_reg >= {1'b0, repel_radius_reg});
    assign status.span_zero     = (repel_span_reg == '0);
    assign status.within_limit  = (sq_reg <= limsq_reg);
    assign status.sqrt_done     = sqrt_done;
    assign status.div_done      = div_done;

    assign out_data = out_reg;

    // agent state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg    <= RST_MAX_SPEED;
            max_force_reg    <= RST_MAX_FORCE;
            slow_radius_reg  <= RST_SLOW_RADIUS;
            repel_radius_reg <= RST_REPEL_RADIUS;
            repel_span_reg   <= RST_REPEL_SPAN;
            repel_gain_reg   <= RST_REPEL_GAIN;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            vel_x_reg        <= '0;
            vel_y_reg        <= '0;
            acc_x_reg        <= '0;
            acc_y_reg        <= '0;
            rep_x_reg        <= '0;
            rep_y_reg        <= '0;
        end else begin
            unique case (op)
                OP_ACC_ADD:
                begin
                    acc_x_reg <= sat32(sx66(acc_x_reg) + sx66(vx_reg));
                    acc_y_reg <= sat32(sx66(acc_y_reg) + sx66(vy_reg));
                end
                OP_GAIN_X:   rep_x_reg <= sat32(sx66(rep_x_reg) + gain_s);
                OP_GAIN_Y:   rep_y_reg <= sat32(sx66(rep_y_reg) + gain_s);
                OP_ACC_REP:
                begin
                    acc_x_reg <= sat32(sx66(acc_x_reg) + sx66(rep_x_reg));
                    acc_y_reg <= sat32(sx66(acc_y_reg) + sx66(rep_y_reg));
                end
                OP_CLEAR_REP:
                begin
                    rep_x_reg <= '0;
                    rep_y_reg <= '0;
                end
                OP_STEP_END:
                begin
                    vel_x_reg <= vx_reg;
                    vel_y_reg <= vy_reg;
                    pos_x_reg <= sat32(sx66(pos_x_reg) + sx66(vx_reg));
                    pos_y_reg <= sat32(sx66(pos_y_reg) + sx66(vy_reg));
                    acc_x_reg <= '0;
                    acc_y_reg <= '0;
                end
                default: ;
            endcase
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_SPEED:    max_speed_reg    <= cfg_data[30:0];
                    CFG_MAX_FORCE:    max_force_reg    <= cfg_data[30:0];
                    CFG_SLOW_RADIUS:  slow_radius_reg  <= cfg_data[30:0];
                    CFG_REPEL_RADIUS: repel_radius_reg <= cfg_data[30:0];
                    CFG_REPEL_SPAN:   repel_span_reg   <= cfg_data[30:0];
                    CFG_REPEL_GAIN:   repel_gain_reg   <= cfg_data[16:0];
                    CFG_START_X:
                    begin
                        start_x_reg <= cfg_data;
                        pos_x_reg   <= cfg_data;
                    end
                    CFG_START_Y:
                    begin
                        start_y_reg <= cfg_data;
                        pos_y_reg   <= cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (sqrt_done)
        begin
            len_reg <= root;
        end
        unique case (op)
            OP_LOAD:
            begin
                cmd_reg   <= in_data.command;
                tgt_x_reg <= in_data.target_x;
                tgt_y_reg <= in_data.target_y;
            end
            OP_DIFF_TP:
            begin
                vx_reg <= sat32(sx66(tgt_x_reg) - sx66(pos_x_reg));
                vy_reg <= sat32(sx66(tgt_y_reg) - sx66(pos_y_reg));
            end
            OP_DIFF_PT:
            begin
                vx_reg <= sat32(sx66(pos_x_reg) - sx66(tgt_x_reg));
                vy_reg <= sat32(sx66(pos_y_reg) - sx66(tgt_y_reg));
            end
            OP_VEL_ACC:
            begin
                vx_reg <= sat32(sx66(vel_x_reg) + sx66(acc_x_reg));
                vy_reg <= sat32(sx66(vel_y_reg) + sx66(acc_y_reg));
            end
            OP_SQ_X:  sq_reg    <= prod;
            OP_SQ_Y:  sq_reg    <= sq_reg + prod;
            OP_LIMSQ: limsq_reg <= prod;
            OP_SET_SEEK:
            begin
                num_reg  <= {1'b0, max_speed_reg};
                den_reg  <= slow_now ? {1'b0, slow_radius_reg} : len_reg;
                wneg_reg <= 1'b0;
            end
            OP_SET_LIMIT:
            begin
                num_reg  <= lim;
                den_reg  <= len_reg;
                wneg_reg <= 1'b0;
            end
            OP_SET_WEIGH:
            begin
                num_reg  <= weight_mag[31:0];
                den_reg  <= {1'b0, repel_span_reg};
                wneg_reg <= weight[32];
            end
            OP_WB_X: vx_reg <= wb_x;
            OP_WB_Y: vy_reg <= wb_y;
            OP_ZERO_V:
            begin
                vx_reg <= '0;
                vy_reg <= '0;
            end
            OP_STEER:
            begin
                vx_reg <= sat32(sx66(vx_reg) - sx66(vel_x_reg));
                vy_reg <= sat32(sx66(vy_reg) - sx66(vel_y_reg));
            end
            OP_EMIT:
            begin
                out_reg.pos_x <= pos_x_reg;
                out_reg.pos_y <= pos_y_reg;
                out_reg.vel_x <= vel_x_reg;
                out_reg.vel_y <= vel_y_reg;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### design/steer_ctrl.sv
// Steering controller: sequences each command through the datapath and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none

module steer_ctrl
    import steer_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [2:0] in_cmd,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_op_t          op
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF_TP,
        S_DIFF_PT,
        S_VEL_ACC,
        S_CLEAR,
        S_SQX,
        S_SQY,
        S_LIM_CHK,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_SEEK_CHK,
        S_REP_CHK,
        S_LIM_ENTER,
        S_LIM_SET,
        S_DIVX,
        S_DIVX_W,
        S_WBX,
        S_DIVY,
        S_DIVY_W,
        S_WBY,
        S_STEER,
        S_LIM_END,
        S_GAIN_X,
        S_GAIN_Y,
        S_ACC_REP,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;
    logic       lim_reg, lim_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lim_next       = lim_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op       = OP_LOAD;
                    cmd_next = in_cmd;
                    unique case (in_cmd)
                        CMD_SEEK, CMD_ARRIVE: state_next = S_DIFF_TP;
                        CMD_REPEL:            state_next = S_DIFF_PT;
                        CMD_CLEAR:            state_next = S_CLEAR;
                        CMD_STEP:             state_next = S_VEL_ACC;
                        default:              state_next = S_DONE;
                    endcase
                end
            end
            S_DIFF_TP:
            begin
                op         = OP_DIFF_TP;
                state_next = S_SQX;
            end
            S_DIFF_PT:
            begin
                op         = OP_DIFF_PT;
                state_next = S_SQX;
            end
            S_VEL_ACC:
            begin
                op         = OP_VEL_ACC;
                lim_next   = 1'b1;
                state_next = S_LIM_ENTER;
            end
            S_CLEAR:
            begin
                op         = OP_CLEAR_REP;
                state_next = S_DONE;
            end
            S_LIM_ENTER:
            begin
                op         = OP_LIMSQ;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                op         = OP_SQ_X;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                op         = OP_SQ_Y;
                state_next = lim_reg ? S_LIM_CHK : S_SQRT_GO;
            end
            S_LIM_CHK:
            begin
                state_next = status.within_limit ? S_LIM_END : S_SQRT_GO;
            end
            S_SQRT_GO:
            begin
                op         = OP_SQRT_GO;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    priority if (lim_reg)
                    begin
                        state_next = S_LIM_SET;
                    end else if (cmd_reg == CMD_REPEL)
                    begin
                        state_next = S_REP_CHK;
                    end else begin
                        state_next = S_SEEK_CHK;
                    end
                end
            end
            S_SEEK_CHK:
            begin
                if (status.len_zero)
                begin
                    op         = OP_ZERO_V;
                    state_next = S_STEER;
                end else begin
                    op         = OP_SET_SEEK;
                    state_next = S_DIVX;
                end
            end
            S_REP_CHK:
            begin
                priority if (status.len_ge_radius)
                begin
                    state_next = S_DONE;
                end else if (status.span_zero)
                begin
                    state_next = S_GAIN_X;
                end else begin
                    op         = OP_SET_WEIGH;
                    state_next = S_DIVX;
                end
            end
            S_LIM_SET:
            begin
                op         = OP_SET_LIMIT;
                state_next = S_DIVX;
            end
            S_DIVX:
            begin
                op         = OP_DIV_X;
                state_next = S_DIVX_W;
            end
            S_DIVX_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_WBX;
                end
            end
            S_WBX:
            begin
                op         = OP_WB_X;
                state_next = S_DIVY;
            end
            S_DIVY:
            begin
                op         = OP_DIV_Y;
                state_next = S_DIVY_W;
            end
            S_DIVY_W:
            begin
                if (status.div_done)
                begin
                    state_next = S_WBY;
                end
            end
            S_WBY:
            begin
                op = OP_WB_Y;
                priority if (lim_reg)
                begin
                    state_next = S_LIM_END;
                end else if (cmd_reg == CMD_REPEL)
                begin
                    state_next = S_GAIN_X;
                end else begin
                    state_next = S_STEER;
                end
            end
            S_STEER:
            begin
                op         = OP_STEER;
                lim_next   = 1'b1;
                state_next = S_LIM_ENTER;
            end
            S_LIM_END:
            begin
                lim_next   = 1'b0;
                op         = (cmd_reg == CMD_STEP) ? OP_STEP_END : OP_ACC_ADD;
                state_next = S_DONE;
            end
            S_GAIN_X:
            begin
                op         = OP_GAIN_X;
                state_next = S_GAIN_Y;
            end
            S_GAIN_Y:
            begin
                op         = OP_GAIN_Y;
                state_next = S_ACC_REP;
            end
            S_ACC_REP:
            begin
                op         = OP_ACC_REP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // load the result once the output register is free or being taken
                if (!out_valid_reg || !out_stall)
                begin
                    op             = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_SEEK;
            lim_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            lim_reg       <= lim_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/agent_steering_arrive_step_top.sv
// Top level of the steering agent: controller plus datapath
//
// One agent (position, velocity, acceleration, repulsion force; signed Q15.16).
// Input channel in_valid/in_stall/in_data carries a command (seek, arrive,
// repel, clear repulsion, step) and a target point. Every accepted transaction
// gives exactly one output transaction on out_valid/out_stall/out_data with
// the position and velocity after the command.
// One command is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register. A single square root unit and
// a single divider serve all commands that use them; the next transaction is
// taken the cycle after the result is loaded.
// A stalled result stays in the output register; the next transaction is
// accepted meanwhile and its result waits until the register is taken.
// Reset loads the configuration defaults, zeroes velocity, acceleration and
// repulsion, and puts the position at the start registers (zero).
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// writing a start register also moves the position.
`timescale 1ns / 1ps
`default_nettype none

module agent_steering_arrive_step_top
    import steer_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_t                in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_t                    out_data,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [DataW-1:0]   cfg_data
);

    dp_op_t     op;
    dp_status_t status;

    steer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.command),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    steer_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
